@@ rtl/disparity_edge_preserving_line_pass_unit_defines.svh @@
// Assertion macros used by the checker of this block.
// Every macro samples on the rising edge of clock.
`ifndef DISPARITY_EDGE_PRESERVING_LINE_PASS_UNIT_DEFINES_SVH
`define DISPARITY_EDGE_PRESERVING_LINE_PASS_UNIT_DEFINES_SVH

// Same-cycle implication, ignored while reset is high.
`define DEPL_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, ignored while reset is high.
`define DEPL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

// Condition that must hold in the cycle after reset is seen high.
`define DEPL_ASSERT_AFTER_RESET(label, cons) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error("post-reset check failed");

`endif

@@ rtl/depl_pkg.sv @@
`default_nettype none

package depl_pkg;

   localparam int PIXEL_WIDTH  = 15;
   localparam int WEIGHT_WIDTH = 9;
   localparam int THRESH_WIDTH = 16;
   localparam int LIMIT_WIDTH  = 8;
   localparam int Q8_SHIFT     = 8;

   localparam int TDATA_WIDTH  = ((PIXEL_WIDTH + 7) / 8) * 8;
   localparam int CMP_WIDTH    = PIXEL_WIDTH + THRESH_WIDTH;
   localparam int DIFF_WIDTH   = PIXEL_WIDTH + 1;
   localparam int PROD_WIDTH   = DIFF_WIDTH + WEIGHT_WIDTH + 1;

   localparam logic [WEIGHT_WIDTH-1:0] Q8_ONE = WEIGHT_WIDTH'(256);

   localparam logic [WEIGHT_WIDTH-1:0] BLEND_WEIGHT_RESET = WEIGHT_WIDTH'(128);
   localparam logic [THRESH_WIDTH-1:0] EDGE_THRESHOLD_RESET = THRESH_WIDTH'(320);
   localparam logic [LIMIT_WIDTH-1:0]  HOLE_LIMIT_RESET = '0;

   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   typedef enum logic [1:0] {
      REG_BLEND_WEIGHT   = 2'd0,
      REG_EDGE_THRESHOLD = 2'd1,
      REG_HOLE_LIMIT     = 2'd2
   } depl_reg_type;

   typedef struct packed {
      logic [WEIGHT_WIDTH-1:0] blend_weight;
      logic [THRESH_WIDTH-1:0] edge_threshold;
      logic [LIMIT_WIDTH-1:0]  hole_bridge_limit;
   } depl_cfg_type;

   typedef struct packed {
      logic                   line_start;
      logic [PIXEL_WIDTH-1:0] pixel;
   } depl_item_type;

endpackage

`default_nettype wire

@@ rtl/depl_csr.sv @@
`default_nettype none

module depl_csr
   import depl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output depl_cfg_type                   cfg
);

   logic [WEIGHT_WIDTH-1:0] blend_weight_ff, blend_weight_in;
   logic [THRESH_WIDTH-1:0] edge_threshold_ff, edge_threshold_in;
   logic [LIMIT_WIDTH-1:0]  hole_limit_ff, hole_limit_in;
   logic                    write_en;
   depl_reg_type            reg_index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_index  = depl_reg_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]);

   always_comb begin
      blend_weight_in   = blend_weight_ff;
      edge_threshold_in = edge_threshold_ff;
      hole_limit_in     = hole_limit_ff;
      csr_prdata        = '0;
      unique case (reg_index)
         REG_BLEND_WEIGHT: begin
            csr_prdata = CSR_DATA_WIDTH'(blend_weight_ff);
            if (write_en) blend_weight_in = csr_pwdata[WEIGHT_WIDTH-1:0];
         end
         REG_EDGE_THRESHOLD: begin
            csr_prdata = CSR_DATA_WIDTH'(edge_threshold_ff);
            if (write_en) edge_threshold_in = csr_pwdata[THRESH_WIDTH-1:0];
         end
         REG_HOLE_LIMIT: begin
            csr_prdata = CSR_DATA_WIDTH'(hole_limit_ff);
            if (write_en) hole_limit_in = csr_pwdata[LIMIT_WIDTH-1:0];
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_weight_ff   <= BLEND_WEIGHT_RESET;
         edge_threshold_ff <= EDGE_THRESHOLD_RESET;
         hole_limit_ff     <= HOLE_LIMIT_RESET;
      end else begin
         blend_weight_ff   <= blend_weight_in;
         edge_threshold_ff <= edge_threshold_in;
         hole_limit_ff     <= hole_limit_in;
      end
   end

   assign cfg.blend_weight      = blend_weight_ff;
   assign cfg.edge_threshold    = edge_threshold_ff;
   assign cfg.hole_bridge_limit = hole_limit_ff;

endmodule

`default_nettype wire

@@ rtl/depl_core.sv @@
`default_nettype none

module depl_core
   import depl_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire depl_item_type          item,
   input  wire depl_cfg_type           cfg,
   output logic      [PIXEL_WIDTH-1:0] result
);

   logic [PIXEL_WIDTH-1:0] ref_value_ff, ref_value_in;
   logic [LIMIT_WIDTH-1:0] bridged_ff, bridged_in;
   logic                   ref_valid_ff, ref_valid_in;

   logic                          ref_valid_cur;
   logic [LIMIT_WIDTH-1:0]        bridged_cur;
   logic [PIXEL_WIDTH-1:0]        diff_mag;
   logic                          near;
   logic [WEIGHT_WIDTH-1:0]       weight_sat;
   logic signed [DIFF_WIDTH-1:0]  diff_signed;
   logic signed [WEIGHT_WIDTH:0]  weight_signed;
   logic signed [PROD_WIDTH-1:0]  product;
   logic signed [PROD_WIDTH-1:0]  blend_sum;
   logic [PIXEL_WIDTH-1:0]        blended;

   // A line start clears the line state before the item itself is looked at.
   assign ref_valid_cur = item.line_start ? 1'b0 : ref_valid_ff;
   assign bridged_cur   = item.line_start ? '0 : bridged_ff;

   assign diff_mag = (item.pixel > ref_value_ff) ? item.pixel - ref_value_ff
                                                 : ref_value_ff - item.pixel;
   assign near = CMP_WIDTH'(diff_mag) < CMP_WIDTH'(cfg.edge_threshold);

   // w*cur + (256-w)*ref equals 256*ref + w*(cur-ref), so the blend needs a
   // single signed multiply; the arithmetic shift keeps the floor rounding.
   assign weight_sat    = (cfg.blend_weight > Q8_ONE) ? Q8_ONE : cfg.blend_weight;
   assign weight_signed = signed'({1'b0, weight_sat});
   assign diff_signed   = signed'({1'b0, item.pixel}) - signed'({1'b0, ref_value_ff});
   assign product       = PROD_WIDTH'(weight_signed) * PROD_WIDTH'(diff_signed);
   assign blend_sum     = (product >>> Q8_SHIFT) + PROD_WIDTH'(signed'({1'b0, ref_value_ff}));
   assign blended       = blend_sum[PIXEL_WIDTH-1:0];

   always_comb begin
      result       = '0;
      ref_value_in = ref_value_ff;
      ref_valid_in = ref_valid_cur;
      bridged_in   = bridged_cur;
      if (item.pixel == '0) begin
         if (ref_valid_cur && (bridged_cur < cfg.hole_bridge_limit)) begin
            result     = ref_value_ff;
            bridged_in = bridged_cur + LIMIT_WIDTH'(1);
         end
      end else if (!ref_valid_cur) begin
         result       = item.pixel;
         ref_value_in = item.pixel;
         ref_valid_in = 1'b1;
         bridged_in   = '0;
      end else begin
         result       = near ? blended : item.pixel;
         ref_value_in = result;
         bridged_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_value_ff <= '0;
         bridged_ff   <= '0;
         ref_valid_ff <= 1'b0;
      end else if (advance) begin
         ref_value_ff <= ref_value_in;
         bridged_ff   <= bridged_in;
         ref_valid_ff <= ref_valid_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/disparity_edge_preserving_line_pass_unit.sv @@
// Left-to-right edge-preserving filter for Q4 disparity scan lines.
// Pixels enter on the req_ stream in scan order, one item per pixel, with
// req_tuser high on the first pixel of each line. Zero is a hole. Each
// accepted item yields exactly one filtered pixel on the rsp_ stream, in order.
// The input register feeds the filter update and blend, which load the
// result register that drives rsp_tvalid. Throughput is one item per cycle
// while the receiver does not stall; the reference-value update is
// combinational, so consecutive pixels of a line follow with no gap.
// When the receiver stalls, the result register holds its item and the input
// register takes one more; req_tready drops only when both are full.
// Reset empties both registers, clears the line state, and returns blend
// weight to 128, edge threshold to 320 and hole bridge limit to 0.
// The csr_ port holds those three registers at byte addresses 0, 4 and 8;
// write them only while no item is in flight.
`default_nettype none

module disparity_edge_preserving_line_pass_unit
   import depl_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [TDATA_WIDTH-1:0]    req_tdata,   // [14:0] pixel_in, rest zero
   input  wire logic                      req_tuser,   // [0] line_start
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [TDATA_WIDTH-1:0]    rsp_tdata,   // [14:0] pixel_out, rest zero
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   depl_cfg_type           cfg;
   depl_item_type          in_item_ff, in_item_in;
   logic                   in_valid_ff, in_valid_in;
   logic                   out_valid_ff, out_valid_in;
   logic [PIXEL_WIDTH-1:0] out_pixel_ff, out_pixel_in;
   logic [PIXEL_WIDTH-1:0] result;
   logic                   req_accept;
   logic                   advance;

   depl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   depl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_item_in   = in_item_ff;
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      if (rsp_tready) out_valid_in = 1'b0;
      if (advance) begin
         in_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         out_pixel_in = result;
      end
      if (req_accept) begin
         in_valid_in           = 1'b1;
         in_item_in.pixel      = req_tdata[PIXEL_WIDTH-1:0];
         in_item_in.line_start = req_tuser;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_item_ff   <= in_item_in;
      out_pixel_ff <= out_pixel_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = TDATA_WIDTH'(out_pixel_ff);

endmodule

`default_nettype wire

@@ rtl/depl_checker.sv @@
`default_nettype none
`include "disparity_edge_preserving_line_pass_unit_defines.svh"

module depl_checker
   import depl_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [TDATA_WIDTH-1:0] rsp_tdata,
   input wire logic                   csr_pready
);

   // Items accepted but not yet delivered; the block buffers at most two.
   logic [1:0] pending_ff, pending_in;
   logic       in_acc;
   logic       out_acc;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;

   always_comb begin
      pending_in = pending_ff;
      if (in_acc && !out_acc) pending_in = pending_ff + 2'd1;
      if (!in_acc && out_acc) pending_in = pending_ff - 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   `DEPL_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `DEPL_ASSERT_SAME(a_pending_bound, 1'b1, pending_ff != 2'd3 && csr_pready)
   `DEPL_ASSERT_SAME(a_no_invented_item, rsp_tvalid, pending_ff != 2'd0)
   `DEPL_ASSERT_SAME(a_ready_when_empty, pending_ff == 2'd0, req_tready)
   `DEPL_ASSERT_AFTER_RESET(a_reset_empty, !rsp_tvalid)

endmodule

bind disparity_edge_preserving_line_pass_unit depl_checker u_depl_checker (.*);

`default_nettype wire
